FILE: design/midpoint_circle_rasterizer_unit_assert.svh
// Assertion macros for the midpoint circle rasterizer checker.
// Expects signals clk and rst in the scope of each use.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_UNIT_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CMRZ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cmrz assertion failed");

// Next-cycle implication.
`define CMRZ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cmrz assertion failed");

`endif

FILE: design/cmrz_pkg.sv
// Shared types and constants for the midpoint circle rasterizer.
// No dependencies.
`default_nettype none
package cmrz_pkg;

  localparam int COORD_BITS     = 12;
  localparam int DEC_BITS       = COORD_BITS + 2;
  localparam int OUT_BITS       = COORD_BITS + 2;
  localparam int CENTER_BITS    = 12;
  localparam int RADIUS_BITS    = 11;
  localparam int CFG_DATA_BITS  = 12;
  localparam int CFG_INDEX_BITS = 2;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int PIX_PER_STEP   = 8;
  localparam int PIX_IDX_BITS   = $clog2(PIX_PER_STEP);

  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS   = CFG_INDEX_BITS'(2);

  localparam logic [PIX_IDX_BITS-1:0] PIX_IDX_LAST = PIX_IDX_BITS'(PIX_PER_STEP - 1);

  typedef struct packed {
    logic                  done;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
  } step_t;

  typedef struct packed {
    logic [CENTER_BITS-1:0] cx;
    logic [CENTER_BITS-1:0] cy;
  } center_t;

endpackage
`default_nettype wire

FILE: design/cmrz_front.sv
// Front end: configuration registers and the midpoint step state.
// Classifies each accepted item into a step entry. Depends on cmrz_pkg.
`default_nettype none
module cmrz_front import cmrz_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic                      restart,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output step_t                     entry,
  output center_t                   center
);

  logic [RADIUS_BITS-1:0] radius;
  logic [COORD_BITS-1:0]  col, col_next, col_inc;
  logic [COORD_BITS-1:0]  row, row_next, row_dec;
  logic [DEC_BITS-1:0]    decision, decision_next, diff;
  logic                   done;

  always_ff @(posedge clk) begin
    if (rst) begin
      center <= '0;
      radius <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X: center.cx <= cfg_data[CENTER_BITS-1:0];
        REG_CENTER_Y: center.cy <= cfg_data[CENTER_BITS-1:0];
        REG_RADIUS:   radius    <= cfg_data[RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    col_inc       = col + 1'b1;
    row_dec       = row - 1'b1;
    diff          = DEC_BITS'(col_inc) - DEC_BITS'(row_dec);
    col_next      = col;
    row_next      = row;
    decision_next = decision;
    done          = 1'b0;
    priority if (restart) begin
      col_next      = '0;
      row_next      = COORD_BITS'(radius);
      decision_next = DEC_BITS'(1) - DEC_BITS'(radius);
    end else if (col >= row) begin
      done = 1'b1;
    end else begin
      col_next = col_inc;
      if (decision[DEC_BITS-1]) begin
        decision_next = decision + DEC_BITS'({col_inc, 1'b1});
      end else begin
        row_next      = row_dec;
        decision_next = decision + {diff[DEC_BITS-2:0], 1'b1};
      end
    end
  end

  assign entry.done = done;
  assign entry.col  = col_next;
  assign entry.row  = row_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      decision <= '0;
    end else if (accept) begin
      col      <= col_next;
      row      <= row_next;
      decision <= decision_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/cmrz_fifo.sv
// Short register queue of step entries between front and back end.
// Depends on cmrz_pkg.
`default_nettype none
module cmrz_fifo import cmrz_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  step_t wr_data,
  input  logic  rd_en,
  output step_t rd_data,
  output logic  full,
  output logic  empty
);

  step_t                mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full    = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/cmrz_back.sv
// Back end: expands each step entry into eight symmetric pixels or one
// done result, through an output register. Depends on cmrz_pkg.
`default_nettype none
module cmrz_back import cmrz_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  step_t                      q_head,
  output logic                       q_pop,
  input  center_t                    center,
  input  logic                       pop,
  output logic                       empty,
  output logic signed [OUT_BITS-1:0] pixel_x,
  output logic signed [OUT_BITS-1:0] pixel_y,
  output logic                       circle_done,
  output logic                       last
);

  logic                    out_valid;
  logic                    load;
  logic [PIX_IDX_BITS-1:0] idx;
  logic [COORD_BITS-1:0]   a, b;
  logic [OUT_BITS-1:0]     cx_ext, cy_ext, px, py;
  logic                    idx_last;

  assign empty    = !out_valid;
  assign load     = !q_empty && (!out_valid || pop);
  assign idx_last = (idx == PIX_IDX_LAST);
  assign q_pop    = load && (q_head.done || idx_last);

  always_comb begin
    a      = idx[2] ? q_head.row : q_head.col;
    b      = idx[2] ? q_head.col : q_head.row;
    cx_ext = OUT_BITS'(center.cx);
    cy_ext = OUT_BITS'(center.cy);
    px     = idx[0] ? cx_ext - OUT_BITS'(a) : cx_ext + OUT_BITS'(a);
    py     = idx[1] ? cy_ext - OUT_BITS'(b) : cy_ext + OUT_BITS'(b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        idx <= '0;
      end else if (load) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (q_head.done) begin
        pixel_x     <= '0;
        pixel_y     <= '0;
        circle_done <= 1'b1;
        last        <= 1'b1;
      end else begin
        pixel_x     <= px;
        pixel_y     <= py;
        circle_done <= 1'b0;
        last        <= idx_last;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/midpoint_circle_rasterizer_unit.sv
// Top level of the midpoint circle rasterizer.
// Depends on cmrz_pkg, cmrz_front, cmrz_fifo and cmrz_back.
//
// Usage:
//   Write center_x (index 0), center_y (index 1) and radius (index 2) on the
//   cfg port while the block is idle. Push an item with restart high to
//   start a circle, then items with restart low to walk one octant step
//   each. Each restart or step yields eight pixel results, the last one
//   flagged by last; a step past the end of the octant yields a single
//   result with circle_done and last set.
//   Input transfer: push high while full is low. Result transfer: pop high
//   while empty is low; the oldest result is on the ports while empty is low.
//   The first result of an item passes through the step queue and then the
//   output register before it is on the ports.
//   Throughput: one result per cycle from the output register while pop is
//   held and the queue holds entries; the front end takes an item every
//   cycle until the two-entry step queue fills.
//   Reset clears the configuration, the step state, the queue and the
//   output valid flag. When the receiver stalls the result holds, the queue
//   fills and full rises.
`default_nettype none
module midpoint_circle_rasterizer_unit import cmrz_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       restart,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [OUT_BITS-1:0] pixel_x,
  output logic signed [OUT_BITS-1:0] pixel_y,
  output logic                       circle_done,
  output logic                       last,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data
);

  logic    accept;
  step_t   entry;
  step_t   q_head;
  center_t center;
  logic    q_empty;
  logic    q_pop;

  assign accept = push && !full;

  cmrz_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .restart   (restart),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .entry     (entry),
    .center    (center)
  );

  cmrz_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (entry),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .full    (full),
    .empty   (q_empty)
  );

  cmrz_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .center      (center),
    .pop         (pop),
    .empty       (empty),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .circle_done (circle_done),
    .last        (last)
  );

endmodule
`default_nettype wire

FILE: design/cmrz_checker.sv
// Port-level checker for the midpoint circle rasterizer, bound to the top.
// Depends on cmrz_pkg and midpoint_circle_rasterizer_unit_assert.svh.
`default_nettype none
`include "midpoint_circle_rasterizer_unit_assert.svh"
module cmrz_checker import cmrz_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       empty,
  input logic                       pop,
  input logic signed [OUT_BITS-1:0] pixel_x,
  input logic signed [OUT_BITS-1:0] pixel_y,
  input logic                       circle_done,
  input logic                       last
);

  `CMRZ_ASSERT_NOW(a_done_is_last, !empty && circle_done, last)
  `CMRZ_ASSERT_NOW(a_done_no_pixel, !empty && circle_done, pixel_x == '0 && pixel_y == '0)
  `CMRZ_ASSERT_NEXT(a_burst_continues, !empty && pop && !last, !empty)
  `CMRZ_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(pixel_x) && $stable(pixel_y) && $stable(circle_done) && $stable(last))

endmodule

bind midpoint_circle_rasterizer_unit cmrz_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .pixel_x     (pixel_x),
  .pixel_y     (pixel_y),
  .circle_done (circle_done),
  .last        (last)
);
`default_nettype wire
